// ===== rtl/core/ttcw_pkg.sv =====
`timescale 1ns / 1ps

package ttcw_pkg;

  localparam int COLUMNS   = 80;
  localparam int CELLS     = 2000;
  localparam int ROW_LIMIT = 127;

  localparam logic [7:0] TAB_STEP   = 8'd4;
  localparam logic [7:0] BLANK_CHAR = 8'h20;

  localparam logic [7:0] COLS_W     = 8'(COLUMNS);
  localparam logic [6:0] COL_LAST   = 7'(COLUMNS - 1);
  localparam logic [6:0] ROW_MAX    = 7'(ROW_LIMIT);
  localparam logic [14:0] CELLS_W   = 15'(CELLS);

  localparam logic [7:0] RST_BACKSPACE = 8'd8;
  localparam logic [7:0] RST_RETURN    = 8'd10;
  localparam logic [7:0] RST_TAB       = 8'd9;

  typedef enum logic [1:0] {
    REG_BACKSPACE = 2'd0,
    REG_RETURN    = 2'd1,
    REG_TAB       = 2'd2
  } reg_idx_t;

  typedef enum logic {
    FUNC_PUT_CHAR = 1'b0,
    FUNC_SET_POS  = 1'b1
  } func_t;

  typedef struct packed {
    logic [7:0] backspace;
    logic [7:0] ret;
    logic [7:0] tab;
  } codes_t;

  typedef struct packed {
    logic [6:0] col;
    logic [6:0] row;
  } cursor_t;

  typedef struct packed {
    logic        we;
    logic [13:0] idx;
    logic [7:0]  chr;
    logic [13:0] pos;
  } result_t;

  // row * COLUMNS + col, kept to 14 bits
  function automatic logic [13:0] linear_idx(input logic [6:0] col, input logic [6:0] row);
    logic [14:0] prod;
    prod = {8'b0, row} * 15'(COLUMNS) + {8'b0, col};
    return prod[13:0];
  endfunction

endpackage

// ===== rtl/core/text_terminal_cursor_writer.sv =====
`timescale 1ns / 1ps

// channel | direction | tdata fields (low bit up)                          | tuser
// in_     | slave     | ch[7:0] new_col[14:8] new_row[21:15] pad[23:22]    | func
// out_    | master    | cell_index[13:0] cell_char[21:14] cursor_pos[35:22] | write_enable
// cfg_    | slave     | cfg_index selects register, cfg_data is the value   | -
//
// one item per cycle sustained while out_tready stays high; an item passes from in_ accept to out_ valid
// through the input register, then the cursor update into the result register
// the cursor column and row live in one register updated as an item moves to the output
// rst_n clears the cursor to column 0, row 1 and restores the default control codes
// a stalled out_tready holds the result register and the staged item; in_tready drops
// only when both are full

module text_terminal_cursor_writer import ttcw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // ch, new_col, new_row, zero pad
  input  logic        in_tuser,   // func

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // cell_index, cell_char, cursor_pos, zero pad
  output logic        out_tuser,  // write_enable

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  codes_t     codes;
  cursor_t    cur_r;
  cursor_t    cur_nxt;
  result_t    res_nxt;
  result_t    out_res_r;
  logic       out_v_r;
  logic       s1_v_r;
  logic       s1_func_r;
  logic [7:0] s1_ch_r;
  logic [6:0] s1_col_r;
  logic [6:0] s1_row_r;
  logic       adv;
  logic       in_fire;

  assign cfg_ready = 1'b1;

  ttcw_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .codes    (codes)
  );

  ttcw_cursor_step u_step (
    .cur     (cur_r),
    .func    (s1_func_r),
    .ch      (s1_ch_r),
    .new_col (s1_col_r),
    .new_row (s1_row_r),
    .codes   (codes),
    .nxt     (cur_nxt),
    .res     (res_nxt)
  );

  assign adv       = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      cur_r   <= '{col: 7'd0, row: 7'd1};
    end else begin
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= 1'b1;
        cur_r   <= cur_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r <= in_tuser;
      s1_ch_r   <= in_tdata[7:0];
      s1_col_r  <= in_tdata[14:8];
      s1_row_r  <= in_tdata[21:15];
    end
    if (adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_res_r.we;
  assign out_tdata  = {4'b0, out_res_r.pos, out_res_r.chr, out_res_r.idx};

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cur_r.col} < COLS_W)
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r.row <= ROW_MAX)
    else $error("cursor row above limit");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_res_r.we) |-> (out_res_r.idx == 14'd0 && out_res_r.chr == 8'd0))
    else $error("dropped write carries nonzero cell fields");

  a_stall_holds_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_tready) |=> $stable(cur_r))
    else $error("cursor moved while output stalled");

endmodule

// ===== rtl/core/ttcw_cfg_regs.sv =====
`timescale 1ns / 1ps

module ttcw_cfg_regs import ttcw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [7:0] wr_data,
  output codes_t     codes
);

  codes_t codes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.backspace <= RST_BACKSPACE;
      codes_r.ret       <= RST_RETURN;
      codes_r.tab       <= RST_TAB;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_BACKSPACE: codes_r.backspace <= wr_data;
        REG_RETURN:    codes_r.ret       <= wr_data;
        REG_TAB:       codes_r.tab       <= wr_data;
        default: ;
      endcase
    end
  end

  assign codes = codes_r;

endmodule

// ===== rtl/core/ttcw_cursor_step.sv =====
`timescale 1ns / 1ps

module ttcw_cursor_step import ttcw_pkg::*; (
  input  cursor_t    cur,
  input  logic       func,
  input  logic [7:0] ch,
  input  logic [6:0] new_col,
  input  logic [6:0] new_row,
  input  codes_t     codes,
  output cursor_t    nxt,
  output result_t    res
);

  logic [7:0] col_inc;
  logic [7:0] col_tab;
  logic [6:0] row_adv;
  logic       wr;
  logic [6:0] wr_col;
  logic [6:0] wr_row;
  logic [7:0] wr_char;
  logic [13:0] wr_idx;
  logic       wr_ok;

  always_comb begin
    col_inc = {1'b0, cur.col} + 8'd1;
    col_tab = {1'b0, cur.col} + TAB_STEP;
    row_adv = (cur.row >= ROW_MAX) ? ROW_MAX : cur.row + 7'd1;

    nxt     = cur;
    wr      = 1'b0;
    wr_col  = cur.col;
    wr_row  = cur.row;
    wr_char = ch;

    priority if (func == FUNC_SET_POS) begin
      nxt.col = ({1'b0, new_col} >= COLS_W) ? COL_LAST : new_col;
      nxt.row = (new_row > ROW_MAX) ? ROW_MAX : new_row;
    end else if (ch == codes.backspace) begin
      // step back, wrapping to the end of the previous line; origin stays put
      if (cur.col != 7'd0) begin
        nxt.col = cur.col - 7'd1;
      end else if (cur.row != 7'd0) begin
        nxt.col = COL_LAST;
        nxt.row = cur.row - 7'd1;
      end
      wr      = 1'b1;
      wr_col  = nxt.col;
      wr_row  = nxt.row;
      wr_char = BLANK_CHAR;
    end else if (ch == codes.ret) begin
      nxt.col = 7'd0;
      nxt.row = row_adv;
    end else if (ch == codes.tab) begin
      if (col_tab >= COLS_W) begin
        nxt.col = 7'(col_tab - COLS_W);
        nxt.row = row_adv;
      end else begin
        nxt.col = col_tab[6:0];
      end
    end else begin
      wr = 1'b1;
      if (col_inc >= COLS_W) begin
        nxt.col = 7'd0;
        nxt.row = row_adv;
      end else begin
        nxt.col = col_inc[6:0];
      end
    end

    wr_idx = linear_idx(wr_col, wr_row);
    // writes past the end of the cell memory are dropped
    wr_ok  = wr && ({1'b0, wr_idx} < CELLS_W);

    res.we  = wr_ok;
    res.idx = wr_ok ? wr_idx : 14'd0;
    res.chr = wr_ok ? wr_char : 8'd0;
    res.pos = linear_idx(nxt.col, nxt.row);
  end

endmodule

// ===== verif/text_terminal_cursor_writer_tb.sv =====
`timescale 1ns / 1ps

module text_terminal_cursor_writer_tb;
  import ttcw_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // ch, new_col, new_row, zero pad
  logic        in_tuser;   // func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;  // cell_index, cell_char, cursor_pos, zero pad
  logic        out_tuser;  // write_enable
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  text_terminal_cursor_writer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // terminal state as the block should hold it
  codes_t  codes;
  int      cur_col;
  int      cur_row;
  result_t pending_cells[$];

  int      errors     = 0;
  int      n_items    = 0;
  int      n_writes   = 0;
  int      n_cfg      = 0;
  int      n_out      = 0;
  int      acc_seen   = 0;
  bit      no_idle    = 1'b0;
  int      stall_left = 0;
  result_t got_cell;
  result_t want_cell;

  function automatic int row_next(int r);
    return (r >= ROW_LIMIT) ? ROW_LIMIT : r + 1;
  endfunction

  function automatic result_t predict_cell(func_t f, logic [7:0] c, logic [6:0] nc,
                                           logic [6:0] nr);
    result_t r;
    bit      wr;
    int      idx;
    r   = '0;
    wr  = 1'b0;
    idx = 0;
    if (f == FUNC_SET_POS) begin
      cur_col = (int'(nc) >= COLUMNS) ? COLUMNS - 1 : int'(nc);
      cur_row = (int'(nr) > ROW_LIMIT) ? ROW_LIMIT : int'(nr);
    end else if (c == codes.backspace) begin
      if (cur_col > 0) begin
        cur_col--;
      end else if (cur_row > 0) begin
        cur_col = COLUMNS - 1;
        cur_row--;
      end
      wr    = 1'b1;
      idx   = cur_row * COLUMNS + cur_col;
      r.chr = BLANK_CHAR;
    end else if (c == codes.ret) begin
      cur_col = 0;
      cur_row = row_next(cur_row);
    end else if (c == codes.tab) begin
      cur_col += int'(TAB_STEP);
      if (cur_col >= COLUMNS) begin
        cur_col -= COLUMNS;
        cur_row = row_next(cur_row);
      end
    end else begin
      wr    = 1'b1;
      idx   = cur_row * COLUMNS + cur_col;
      r.chr = c;
      cur_col++;
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        cur_row = row_next(cur_row);
      end
    end
    if (wr && idx < CELLS) begin
      r.we  = 1'b1;
      r.idx = idx[13:0];
    end else begin
      r.chr = '0;
    end
    r.pos = 14'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  // entered and left at a falling edge; tvalid stays high when the next item follows at once
  task automatic send_item(func_t f, logic [7:0] c, logic [6:0] nc, logic [6:0] nr);
    int      gap;
    result_t r;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {2'b00, nr, nc, c};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = predict_cell(f, c, nc, nr);
    pending_cells.push_back(r);
    n_items++;
    if (r.we) n_writes++;
    @(negedge clk);
  endtask

  task automatic put_char(logic [7:0] c);
    send_item(FUNC_PUT_CHAR, c, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
  endtask

  task automatic set_pos(logic [6:0] nc, logic [6:0] nr);
    send_item(FUNC_SET_POS, 8'($urandom_range(0, 255)), nc, nr);
  endtask

  // hold the input until every pending result is out, then let the pipeline settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_cells.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_code(reg_idx_t idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_BACKSPACE: codes.backspace = val;
      REG_RETURN:    codes.ret       = val;
      REG_TAB:       codes.tab       = val;
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_codes(logic [7:0] bs, logic [7:0] rt, logic [7:0] tb);
    wait_idle();
    write_code(REG_BACKSPACE, bs);
    write_code(REG_RETURN, rt);
    write_code(REG_TAB, tb);
  endtask

  // output side: random stall after each accepted item
  always @(negedge clk) begin
    if (acc_seen != n_out) begin
      acc_seen   = n_out;
      stall_left = no_idle ? 0 : $urandom_range(0, 6);
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic report_field(string nm, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_cell.we  = out_tuser;
      got_cell.idx = out_tdata[13:0];
      got_cell.chr = out_tdata[21:14];
      got_cell.pos = out_tdata[35:22];
      if (pending_cells.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, actual we=%0d idx=%0d chr=%0d pos=%0d",
                 $time, got_cell.we, got_cell.idx, got_cell.chr, got_cell.pos);
      end else begin
        want_cell = pending_cells.pop_front();
        report_field("write_enable", want_cell.we, got_cell.we);
        report_field("cell_index", want_cell.idx, got_cell.idx);
        report_field("cell_char", want_cell.chr, got_cell.chr);
        report_field("cursor_pos", want_cell.pos, got_cell.pos);
      end
      n_out++;
    end
  end

  task automatic test_default_codes();
    put_char(8'h41);              // first cell of row 1
    put_char(RST_BACKSPACE);
    put_char(RST_TAB);
    put_char(RST_RETURN);
    put_char(8'h00);
    put_char(8'hff);
  endtask

  task automatic test_backspace();
    set_pos(7'd0, 7'd0);
    put_char(codes.backspace);    // origin stays put, cell 0 blanked
    set_pos(7'd0, 7'd5);
    put_char(codes.backspace);    // wraps to the end of row 4
  endtask

  task automatic test_column_wrap();
    set_pos(7'd79, 7'd2);
    put_char(8'h5a);
    set_pos(7'd78, 7'd3);
    put_char(codes.tab);
    set_pos(7'd76, 7'd3);
    put_char(codes.tab);          // lands exactly on the column count
  endtask

  task automatic test_row_limit_and_memory();
    set_pos(7'd79, 7'd24);
    put_char(8'h31);              // last cell in memory
    put_char(8'h32);              // first cell past memory, dropped
    set_pos(7'd5, 7'd127);
    put_char(codes.ret);
    set_pos(7'd79, 7'd127);
    put_char(8'h33);
    set_pos(7'd77, 7'd127);
    put_char(codes.tab);
  endtask

  task automatic test_set_clamp();
    set_pos(7'd127, 7'd127);
    set_pos(7'd80, 7'd0);
    set_pos(7'd0, 7'd1);
  endtask

  task automatic test_code_overlap();
    set_codes(8'h41, 8'h41, 8'h41);   // backspace wins
    set_pos(7'd3, 7'd3);
    put_char(8'h41);
    set_codes(8'h00, 8'h42, 8'h42);   // return wins over tab
    put_char(8'h42);
    put_char(8'h00);
    set_codes(8'hff, 8'h00, 8'h80);
    put_char(8'hff);
    put_char(8'h00);
    put_char(8'h80);
  endtask

  task automatic random_item();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      set_pos(7'($urandom_range(0, 127)),
              ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                           : 7'($urandom_range(0, 30)));
    end else if (sel < 18) begin
      put_char(codes.backspace);
    end else if (sel < 26) begin
      put_char(codes.ret);
    end else if (sel < 36) begin
      put_char(codes.tab);
    end else begin
      put_char(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_traffic();
    int   ph;
    logic [7:0] same;
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_codes(RST_BACKSPACE, RST_RETURN, RST_TAB);
        1: set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        2: set_codes(8'h00, 8'hff, 8'h80);
        3: begin
          same = 8'($urandom_range(0, 255));
          set_codes(same, same, same);
        end
        default: set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
      endcase
      no_idle = (ph == 1);
      repeat (150) random_item();
      no_idle = 1'b0;
      if (ph == 2) wait_idle();       // sender holds off until all results are in
      repeat (150) random_item();
    end
  endtask

  initial begin
    #5_000_000;
    $display("** text_terminal_cursor_writer: FAILED **");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    codes.backspace = RST_BACKSPACE;
    codes.ret       = RST_RETURN;
    codes.tab       = RST_TAB;
    cur_col = 0;
    cur_row = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_default_codes();
    test_backspace();
    test_column_wrap();
    test_row_limit_and_memory();
    test_set_clamp();
    test_code_overlap();
    test_random_traffic();
    wait_idle();

    $display("%0d items sent, %0d cell writes expected, %0d register writes",
             n_items, n_writes, n_cfg);
    $display("covered backspace, return, tab, wrap, row limit, clamping and code overlap");
    if (errors == 0) begin
      $display("** text_terminal_cursor_writer: PASSED **");
    end else begin
      $display("** text_terminal_cursor_writer: FAILED **");
    end
    $finish;
  end

endmodule

// ===== text_terminal_cursor_writer.f =====
rtl/core/ttcw_pkg.sv
rtl/core/ttcw_cfg_regs.sv
rtl/core/ttcw_cursor_step.sv
rtl/core/text_terminal_cursor_writer.sv
verif/text_terminal_cursor_writer_tb.sv
